/* rtl/disk_mask_span_generator_top_macros.svh */
// Assertion macros shared by the disk span generator RTL.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef DISK_MASK_SPAN_GENERATOR_TOP_MACROS_SVH
`define DISK_MASK_SPAN_GENERATOR_TOP_MACROS_SVH

// cond implies prop in the same cycle
`define DMSG_ASSERT_IMPLIES(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// cond implies prop in the next cycle
`define DMSG_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

// cond never holds
`define DMSG_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

/* rtl/dmsg_pkg.sv */
// Package for the disk span generator: widths, register codes, shared types
// and the rounded integer root. No dependencies.
package dmsg_pkg;

   localparam int unsigned MAX_RADIUS    = 31;
   localparam int unsigned MAX_GRID_SIDE = 4096;

   localparam int unsigned COORD_W     = 16;
   localparam int unsigned RADIUS_W    = 5;
   localparam int unsigned SIDE_W      = 13;
   localparam int unsigned ROW_W       = 12;
   localparam int unsigned INDEX_W     = 24;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned DELTA_W     = 6;
   localparam int unsigned KSQ_W       = 10;
   localparam int unsigned ROOT_W      = 6;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 13;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DISK_RADIUS = 2'd0,
      REG_GRID_WIDTH  = 2'd1,
      REG_GRID_HEIGHT = 2'd2
   } dmsg_reg_type;

   typedef struct packed {
      logic [RADIUS_W-1:0] disk_radius;
      logic [SIDE_W-1:0]   grid_width;
      logic [SIDE_W-1:0]   grid_height;
   } dmsg_cfg_type;

   // one classified point: empty flag, clipped row range, first row offset and center column
   typedef struct packed {
      logic                      empty;
      logic [ROW_W-1:0]          first_row;
      logic [ROW_W-1:0]          last_row;
      logic signed [DELTA_W-1:0] d_first;
      logic signed [COORD_W-1:0] center_col;
   } dmsg_point_type;

   // sqrt(k) rounded to nearest, two bits of k per step
   function automatic logic [ROOT_W-1:0] round_root(input logic [KSQ_W-1:0] k);
      logic [11:0]       rem;
      logic [11:0]       trial;
      logic [ROOT_W-1:0] root;
      rem  = '0;
      root = '0;
      for (int i = KSQ_W/2 - 1; i >= 0; i--) begin
         rem   = {rem[9:0], k[2*i+1 -: 2]};
         trial = {4'd0, root, 2'b01};
         if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[ROOT_W-2:0], 1'b1};
         end else begin
            root = {root[ROOT_W-2:0], 1'b0};
         end
      end
      if (rem > {6'd0, root}) begin
         root = root + 6'd1;
      end
      return root;
   endfunction

endpackage

/* rtl/dmsg_if.sv */
// Channel interfaces of the disk span generator: point input, span output
// and register write port. Depends on dmsg_pkg.
interface dmsg_req_if import dmsg_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] center_col;
   logic signed [COORD_W-1:0] center_row;
   modport source (output valid, center_col, center_row, input ready);
   modport sink   (input valid, center_col, center_row, output ready);
endinterface

interface dmsg_rsp_if import dmsg_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] span_start;
   logic [INDEX_W-1:0] span_end;
   logic [COUNT_W-1:0] span_number;
   logic               empty_point;
   logic               last_span;
   modport source (output valid, span_start, span_end, span_number, empty_point, last_span,
                   input ready);
   modport sink   (input valid, span_start, span_end, span_number, empty_point, last_span,
                   output ready);
endinterface

interface dmsg_csr_if import dmsg_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/disk_mask_span_generator_top.sv */
// Disk span generator top level: config registers, front end, point queue
// and back end. Depends on dmsg_pkg, the channel interfaces and all submodules.
//
// Use: write disk_radius (index 0), grid_width (1) and grid_height (2) on
// csr_ch while no point is in flight; writes are taken every cycle and any
// other index is dropped. Send points on req_ch as rounded center column and
// row. For each point rsp_ch returns one span per disk row that lands inside
// the grid, top row first, as linear start and end indices with a running
// span number; the final span carries last_span. A point with no span inside
// the grid returns one item with empty_point and last_span set.
// Throughput: one span per cycle while rsp_ch is ready; for each point the row
// generator walks its clipped rows (at least one) into the root and clip
// pipeline, then the held-back last span is flushed. The front end and a
// two-entry queue accept further points meanwhile.
// When rsp_ch stalls, the output register holds, the pending span and the
// row pipeline freeze, then the queue fills and req_ch.ready drops.
// Reset clears the span counter and all control state and restores
// radius 0, width 1, height 1.
module disk_mask_span_generator_top import dmsg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dmsg_req_if.sink   req_ch,
   dmsg_rsp_if.source rsp_ch,
   dmsg_csr_if.sink   csr_ch
);

   dmsg_cfg_type   cfg_ff, cfg_in;
   logic           push_valid;
   logic           push_ready;
   dmsg_point_type push_data;
   logic           pop_valid;
   logic           pop_ready;
   dmsg_point_type pop_data;

   assign csr_ch.ready = 1'b1;

   // decode register writes, clamp to the supported range
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (dmsg_reg_type'(csr_ch.index))
            REG_DISK_RADIUS: begin
               cfg_in.disk_radius = (32'(csr_ch.data[RADIUS_W-1:0]) > MAX_RADIUS) ?
                  RADIUS_W'(MAX_RADIUS) : csr_ch.data[RADIUS_W-1:0];
            end
            REG_GRID_WIDTH: begin
               cfg_in.grid_width = (32'(csr_ch.data) > MAX_GRID_SIDE) ?
                  SIDE_W'(MAX_GRID_SIDE) : csr_ch.data;
            end
            REG_GRID_HEIGHT: begin
               cfg_in.grid_height = (32'(csr_ch.data) > MAX_GRID_SIDE) ?
                  SIDE_W'(MAX_GRID_SIDE) : csr_ch.data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disk_radius <= '0;
         cfg_ff.grid_width  <= SIDE_W'(1);
         cfg_ff.grid_height <= SIDE_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dmsg_front u_front (
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   dmsg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   dmsg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

/* rtl/dmsg_front.sv */
// Front end: accepts points and clips the disk's row range to the grid.
// Depends on dmsg_pkg and dmsg_req_if.
module dmsg_front import dmsg_pkg::*; (
   dmsg_req_if.sink       req_ch,
   input  dmsg_cfg_type   cfg,
   output logic           push_valid,
   output dmsg_point_type push_data,
   input  logic           push_ready
);

   logic signed [17:0] jc_s;
   logic signed [17:0] r_s;
   logic signed [17:0] n_s;
   logic signed [17:0] lo_raw;
   logic signed [17:0] hi_raw;
   logic signed [17:0] lo_clip;
   logic signed [17:0] hi_clip;
   logic signed [17:0] last_s;
   logic signed [17:0] d_s;

   // clip rows center-r .. center+r to 0 .. height-1
   always_comb begin
      jc_s    = 18'(req_ch.center_row);
      r_s     = signed'({13'd0, cfg.disk_radius});
      n_s     = signed'({5'd0, cfg.grid_height});
      lo_raw  = jc_s - r_s;
      hi_raw  = jc_s + r_s + 18'sd1;
      lo_clip = (lo_raw < 18'sd0) ? 18'sd0 : lo_raw;
      hi_clip = (hi_raw > n_s) ? n_s : hi_raw;
      last_s  = hi_clip - 18'sd1;
      d_s     = jc_s - lo_clip;

      push_data.empty      = (hi_clip <= lo_clip);
      push_data.first_row  = lo_clip[ROW_W-1:0];
      push_data.last_row   = last_s[ROW_W-1:0];
      push_data.d_first    = d_s[DELTA_W-1:0];
      push_data.center_col = req_ch.center_col;
   end

   // hand over straight to the queue
   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

endmodule

/* rtl/dmsg_queue.sv */
// Short queue of classified points between front and back end.
// Depends on dmsg_pkg.
module dmsg_queue import dmsg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  dmsg_point_type push_data,
   output logic           pop_valid,
   input  logic           pop_ready,
   output dmsg_point_type pop_data
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   dmsg_point_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store incoming point
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/dmsg_back.sv */
// Back end: walks the rows of one point, takes the rounded root per row,
// clips columns, forms linear indices and holds one span back to flag the last.
// Depends on dmsg_pkg, dmsg_rsp_if and the assertion macro header.
`include "disk_mask_span_generator_top_macros.svh"

module dmsg_back import dmsg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  dmsg_cfg_type   cfg,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  dmsg_point_type pop_data,
   dmsg_rsp_if.source     rsp_ch
);

   // row generator
   logic                      gen_act_ff, gen_act_in;
   logic [ROW_W-1:0]          gen_j_ff, gen_j_in;
   logic [ROW_W-1:0]          gen_jl_ff, gen_jl_in;
   logic signed [DELTA_W-1:0] gen_d_ff, gen_d_in;
   logic signed [COORD_W-1:0] gen_ic_ff, gen_ic_in;
   logic                      gen_force_ff, gen_force_in;

   logic [KSQ_W-1:0]          rsq_ff, rsq_in;

   // stage A: squared half-width
   logic                      sa_v_ff, sa_v_in;
   logic [KSQ_W-1:0]          sa_k_ff, sa_k_in;
   logic [ROW_W-1:0]          sa_j_ff, sa_j_in;
   logic                      sa_last_ff, sa_last_in;
   logic signed [COORD_W-1:0] sa_ic_ff, sa_ic_in;
   logic                      sa_force_ff, sa_force_in;

   // stage B: half-width and row base index
   logic                      sb_v_ff, sb_v_in;
   logic [ROOT_W-1:0]         sb_h_ff, sb_h_in;
   logic [INDEX_W-1:0]        sb_jm_ff, sb_jm_in;
   logic                      sb_last_ff, sb_last_in;
   logic signed [COORD_W-1:0] sb_ic_ff, sb_ic_in;
   logic                      sb_force_ff, sb_force_in;

   // stage C: clipped columns
   logic                      sc_v_ff, sc_v_in;
   logic [ROW_W-1:0]          sc_a_ff, sc_a_in;
   logic [ROW_W-1:0]          sc_b_ff, sc_b_in;
   logic [INDEX_W-1:0]        sc_jm_ff, sc_jm_in;
   logic                      sc_ok_ff, sc_ok_in;
   logic                      sc_last_ff, sc_last_in;

   // pending span held back one step
   logic                      pd_v_ff, pd_v_in;
   logic                      pd_final_ff, pd_final_in;
   logic                      pd_empty_ff, pd_empty_in;
   logic [INDEX_W-1:0]        pd_start_ff, pd_start_in;
   logic [INDEX_W-1:0]        pd_end_ff, pd_end_in;

   // output register
   logic                      rsp_v_ff, rsp_v_in;
   logic [INDEX_W-1:0]        rsp_start_ff, rsp_start_in;
   logic [INDEX_W-1:0]        rsp_end_ff, rsp_end_in;
   logic [COUNT_W-1:0]        rsp_num_ff, rsp_num_in;
   logic                      rsp_empty_ff, rsp_empty_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]        cnt_ff, cnt_in;

   logic                      o_free;
   logic                      p_flush;
   logic                      need_move;
   logic                      c_take;
   logic                      o_from_c;
   logic                      o_load;
   logic                      adv;
   logic                      issue;
   logic                      row_last;
   logic                      load_gen;
   logic signed [11:0]        dsq_w;
   logic [24:0]               jm_w;
   logic signed [17:0]        ic_s;
   logic signed [17:0]        h_s;
   logic signed [17:0]        mlim_s;
   logic signed [17:0]        a_s;
   logic signed [17:0]        b_s;
   logic signed [17:0]        a_c;
   logic signed [17:0]        b_c;
   logic [INDEX_W-1:0]        c_start;
   logic [INDEX_W-1:0]        c_end;

   // handshake between pending span, output register and row pipeline
   always_comb begin
      o_free    = !rsp_v_ff || rsp_ch.ready;
      p_flush   = pd_v_ff && pd_final_ff && o_free;
      need_move = pd_v_ff && sc_ok_ff;
      c_take    = sc_v_ff && !(pd_v_ff && pd_final_ff) && (!need_move || o_free);
      o_from_c  = c_take && need_move;
      o_load    = p_flush || o_from_c;
      adv       = !sc_v_ff || c_take;
      issue     = adv && gen_act_ff;
      row_last  = gen_force_ff || (gen_j_ff == gen_jl_ff);
      pop_ready = !gen_act_ff || (issue && row_last);
      load_gen  = pop_valid && pop_ready;
   end

   // row generator: load a point, then step one row per advance
   always_comb begin
      gen_act_in   = gen_act_ff;
      gen_j_in     = gen_j_ff;
      gen_jl_in    = gen_jl_ff;
      gen_d_in     = gen_d_ff;
      gen_ic_in    = gen_ic_ff;
      gen_force_in = gen_force_ff;
      if (load_gen) begin
         gen_act_in   = 1'b1;
         gen_j_in     = pop_data.first_row;
         gen_jl_in    = pop_data.last_row;
         gen_d_in     = pop_data.d_first;
         gen_ic_in    = pop_data.center_col;
         gen_force_in = pop_data.empty;
      end else if (issue && row_last) begin
         gen_act_in = 1'b0;
      end else if (issue) begin
         gen_j_in = gen_j_ff + ROW_W'(1);
         gen_d_in = gen_d_ff - DELTA_W'(1);
      end
   end

   // row pipeline stages, frozen while the pending span is stuck
   always_comb begin
      rsq_in = cfg.disk_radius * cfg.disk_radius;
      dsq_w  = gen_d_ff * gen_d_ff;
      jm_w   = sa_j_ff * cfg.grid_width;
      ic_s   = 18'(sb_ic_ff);
      h_s    = signed'({12'd0, sb_h_ff});
      mlim_s = signed'({5'd0, cfg.grid_width}) - 18'sd1;
      a_s    = ic_s - h_s;
      b_s    = ic_s + h_s;
      a_c    = (a_s < 18'sd0) ? 18'sd0 : a_s;
      b_c    = (b_s > mlim_s) ? mlim_s : b_s;

      sa_v_in = sa_v_ff;  sa_k_in = sa_k_ff;  sa_j_in = sa_j_ff;
      sa_last_in = sa_last_ff;  sa_ic_in = sa_ic_ff;  sa_force_in = sa_force_ff;
      sb_v_in = sb_v_ff;  sb_h_in = sb_h_ff;  sb_jm_in = sb_jm_ff;
      sb_last_in = sb_last_ff;  sb_ic_in = sb_ic_ff;  sb_force_in = sb_force_ff;
      sc_v_in = sc_v_ff;  sc_a_in = sc_a_ff;  sc_b_in = sc_b_ff;
      sc_jm_in = sc_jm_ff;  sc_ok_in = sc_ok_ff;  sc_last_in = sc_last_ff;
      if (adv) begin
         sa_v_in     = issue;
         sa_k_in     = rsq_ff - dsq_w[KSQ_W-1:0];
         sa_j_in     = gen_j_ff;
         sa_last_in  = row_last;
         sa_ic_in    = gen_ic_ff;
         sa_force_in = gen_force_ff;

         sb_v_in     = sa_v_ff;
         sb_h_in     = round_root(sa_k_ff);
         sb_jm_in    = jm_w[INDEX_W-1:0];
         sb_last_in  = sa_last_ff;
         sb_ic_in    = sa_ic_ff;
         sb_force_in = sa_force_ff;

         sc_v_in     = sb_v_ff;
         sc_a_in     = a_c[ROW_W-1:0];
         sc_b_in     = b_c[ROW_W-1:0];
         sc_jm_in    = sb_jm_ff;
         sc_ok_in    = !sb_force_ff && (a_c <= b_c);
         sc_last_in  = sb_last_ff;
      end
   end

   // pending span and output register
   always_comb begin
      c_start = {12'd0, sc_a_ff} + sc_jm_ff;
      c_end   = {12'd0, sc_b_ff} + sc_jm_ff;

      pd_v_in     = pd_v_ff;
      pd_final_in = pd_final_ff;
      pd_empty_in = pd_empty_ff;
      pd_start_in = pd_start_ff;
      pd_end_in   = pd_end_ff;
      if (p_flush) begin
         pd_v_in     = 1'b0;
         pd_final_in = 1'b0;
      end else if (c_take) begin
         if (sc_ok_ff) begin
            pd_v_in     = 1'b1;
            pd_final_in = sc_last_ff;
            pd_empty_in = 1'b0;
            pd_start_in = c_start;
            pd_end_in   = c_end;
         end else if (sc_last_ff) begin
            pd_final_in = 1'b1;
            if (!pd_v_ff) begin
               pd_v_in     = 1'b1;
               pd_empty_in = 1'b1;
               pd_start_in = '0;
               pd_end_in   = '0;
            end
         end
      end

      rsp_v_in     = rsp_v_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      cnt_in       = cnt_ff;
      if (o_load) begin
         rsp_v_in     = 1'b1;
         rsp_start_in = pd_start_ff;
         rsp_end_in   = pd_end_ff;
         rsp_num_in   = cnt_ff;
         rsp_empty_in = pd_empty_ff;
         rsp_last_in  = p_flush;
         cnt_in       = cnt_ff + COUNT_W'(!pd_empty_ff);
      end else if (rsp_ch.ready) begin
         rsp_v_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_act_ff  <= 1'b0;
         sa_v_ff     <= 1'b0;
         sb_v_ff     <= 1'b0;
         sc_v_ff     <= 1'b0;
         pd_v_ff     <= 1'b0;
         pd_final_ff <= 1'b0;
         rsp_v_ff    <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         gen_act_ff  <= gen_act_in;
         sa_v_ff     <= sa_v_in;
         sb_v_ff     <= sb_v_in;
         sc_v_ff     <= sc_v_in;
         pd_v_ff     <= pd_v_in;
         pd_final_ff <= pd_final_in;
         rsp_v_ff    <= rsp_v_in;
         cnt_ff      <= cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      gen_j_ff     <= gen_j_in;
      gen_jl_ff    <= gen_jl_in;
      gen_d_ff     <= gen_d_in;
      gen_ic_ff    <= gen_ic_in;
      gen_force_ff <= gen_force_in;
      rsq_ff       <= rsq_in;
      sa_k_ff      <= sa_k_in;
      sa_j_ff      <= sa_j_in;
      sa_last_ff   <= sa_last_in;
      sa_ic_ff     <= sa_ic_in;
      sa_force_ff  <= sa_force_in;
      sb_h_ff      <= sb_h_in;
      sb_jm_ff     <= sb_jm_in;
      sb_last_ff   <= sb_last_in;
      sb_ic_ff     <= sb_ic_in;
      sb_force_ff  <= sb_force_in;
      sc_a_ff      <= sc_a_in;
      sc_b_ff      <= sc_b_in;
      sc_jm_ff     <= sc_jm_in;
      sc_ok_ff     <= sc_ok_in;
      sc_last_ff   <= sc_last_in;
      pd_empty_ff  <= pd_empty_in;
      pd_start_ff  <= pd_start_in;
      pd_end_ff    <= pd_end_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_ch.valid       = rsp_v_ff;
   assign rsp_ch.span_start  = rsp_start_ff;
   assign rsp_ch.span_end    = rsp_end_ff;
   assign rsp_ch.span_number = rsp_num_ff;
   assign rsp_ch.empty_point = rsp_empty_ff;
   assign rsp_ch.last_span   = rsp_last_ff;

   `DMSG_ASSERT_IMPLIES(a_empty_is_last, rsp_v_ff && rsp_empty_ff,
      rsp_last_ff && (rsp_start_ff == '0), "empty point result not flagged last")
   `DMSG_ASSERT_NEXT(a_count_step, o_load && !pd_empty_ff,
      cnt_ff == $past(cnt_ff) + COUNT_W'(1), "span counter missed a step")
   `DMSG_ASSERT_NEVER(a_one_source, p_flush && o_from_c,
      "output register loaded from two sources")
   `DMSG_ASSERT_IMPLIES(a_gen_order, gen_act_ff && !gen_force_ff,
      gen_j_ff <= gen_jl_ff, "row walk ran past the last row")

endmodule

/* sim/tb.sv */
// Testbench for disk_mask_span_generator_top: drives points and register writes,
// predicts every span and checks each in order. Depends on dmsg_pkg, dmsg_if, the top.
`timescale 1ns / 1ps

module tb import dmsg_pkg::*; ;

   localparam int unsigned RESET_CYCLES = 9;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned IDLE_LIMIT   = 4000;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_INDEX = 2'd3;

   // one expected or observed span
   typedef struct packed {
      logic [INDEX_W-1:0] first_index;
      logic [INDEX_W-1:0] last_index;
      logic [COUNT_W-1:0] number;
      logic               empty;
      logic               last;
   } span_rec_type;

   logic clock = 1'b0;
   logic reset;

   dmsg_req_if req_ch ();
   dmsg_rsp_if rsp_ch ();
   dmsg_csr_if csr_ch ();

   disk_mask_span_generator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   int unsigned        cfg_radius;
   int unsigned        cfg_width;
   int unsigned        cfg_height;
   logic [COUNT_W-1:0] span_count;
   span_rec_type       span_queue[$];

   // bookkeeping
   int unsigned mismatches;
   int unsigned points_sent;
   int unsigned spans_seen;
   int unsigned empties_seen;
   int unsigned settings_used;
   int unsigned burst_left;
   int unsigned idle_cycles;
   bit          long_hold_pending;

   function automatic int rounded_half_width(input int k);
      int h;
      h = 0;
      if (k <= 0) return 0;
      while ((h + 1) * (h + 1) <= k) h++;
      if (k > h * h + h) h++;
      return h;
   endfunction

   // append the spans a point produces under the current settings
   task automatic predict_spans(input logic signed [COORD_W-1:0] col,
                                input logic signed [COORD_W-1:0] row);
      int           ic, jc, r, m, n, lo, hi, d, h, a, b, count;
      span_rec_type rec;
      ic = int'(col);
      jc = int'(row);
      r  = cfg_radius;
      m  = cfg_width;
      n  = cfg_height;
      lo = (jc - r < 0) ? 0 : jc - r;
      hi = (jc + r + 1 > n) ? n : jc + r + 1;
      count = 0;
      for (int j = lo; j < hi; j++) begin
         d = jc - j;
         h = rounded_half_width(r * r - d * d);
         a = (ic - h < 0) ? 0 : ic - h;
         b = (ic + h > m - 1) ? m - 1 : ic + h;
         if (a <= b) begin
            rec.first_index = INDEX_W'(a + j * m);
            rec.last_index  = INDEX_W'(b + j * m);
            rec.number      = span_count;
            rec.empty       = 1'b0;
            rec.last        = 1'b0;
            span_queue.push_back(rec);
            span_count = span_count + 1;
            count++;
         end
      end
      if (count == 0) begin
         rec = '0;
         rec.number = span_count;
         rec.empty  = 1'b1;
         rec.last   = 1'b1;
         span_queue.push_back(rec);
      end else begin
         span_queue[span_queue.size() - 1].last = 1'b1;
      end
   endtask

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
   endtask

   // check each span leaving the block against the oldest expectation
   span_rec_type got_span;
   span_rec_type want_span;
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_span = '{rsp_ch.span_start, rsp_ch.span_end, rsp_ch.span_number,
                      rsp_ch.empty_point, rsp_ch.last_span};
         spans_seen++;
         if (rsp_ch.empty_point) empties_seen++;
         if (span_queue.size() == 0) begin
            note_mismatch($sformatf("unexpected span start %0d end %0d number %0d",
                                    got_span.first_index, got_span.last_index,
                                    got_span.number));
         end else begin
            want_span = span_queue.pop_front();
            if (got_span !== want_span) begin
               note_mismatch($sformatf(
                  "start %0d/%0d end %0d/%0d number %0d/%0d empty %b/%b last %b/%b",
                  want_span.first_index, got_span.first_index,
                  want_span.last_index, got_span.last_index,
                  want_span.number, got_span.number,
                  want_span.empty, got_span.empty,
                  want_span.last, got_span.last));
            end
         end
      end
   end

   // end the run when no channel moves an item for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: stretches of free flow, random stalls and a sparse pattern,
   // plus one long hold-off on request
   initial begin
      int unsigned mode;
      int unsigned stretch;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            mode    = $urandom_range(2);
            stretch = $urandom_range(40, 5);
            for (int i = 0; i < stretch; i++) begin
               case (mode)
                  0: rsp_ch.ready <= 1'b1;
                  1: rsp_ch.ready <= ($urandom_range(99) >= 30);
                  default: rsp_ch.ready <= (i % 3 == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // offer one point, in bursts with random gaps, and hold it until taken
   task automatic send_point(input logic signed [COORD_W-1:0] col,
                             input logic signed [COORD_W-1:0] row);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = $urandom_range(12, 1);
      end
      req_ch.valid      <= 1'b1;
      req_ch.center_col <= col;
      req_ch.center_row <= row;
      do @(posedge clock); while (!req_ch.ready);
      predict_spans(col, row);
      points_sent++;
      burst_left--;
   endtask

   // drop the request and wait until every expected span is back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (span_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      int unsigned v;
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (index)
         REG_DISK_RADIUS: begin
            v = 32'(data & 13'h001F);
            cfg_radius = (v > MAX_RADIUS) ? MAX_RADIUS : v;
         end
         REG_GRID_WIDTH: begin
            v = 32'(data);
            cfg_width = (v > MAX_GRID_SIDE) ? MAX_GRID_SIDE : v;
         end
         REG_GRID_HEIGHT: begin
            v = 32'(data);
            cfg_height = (v > MAX_GRID_SIDE) ? MAX_GRID_SIDE : v;
         end
         default: ;
      endcase
   endtask

   // write all three registers while idle
   task automatic set_grid(input logic [CSR_DATA_W-1:0] radius_data,
                           input logic [CSR_DATA_W-1:0] width_data,
                           input logic [CSR_DATA_W-1:0] height_data);
      write_reg(REG_DISK_RADIUS, radius_data);
      write_reg(REG_GRID_WIDTH, width_data);
      write_reg(REG_GRID_HEIGHT, height_data);
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   // pick a center close to the grid so most rows land inside
   task automatic send_near_point();
      int col, row;
      col = int'($urandom_range(cfg_width + 2 * cfg_radius + 5)) - int'(cfg_radius) - 3;
      row = int'($urandom_range(cfg_height + 2 * cfg_radius + 5)) - int'(cfg_radius) - 3;
      send_point(COORD_W'(col), COORD_W'(row));
   endtask

   // reset values: a single-cell grid and a zero radius
   task automatic test_reset_defaults();
      settings_used++;
      send_point(16'sd0, 16'sd0);
      send_point(16'sd1, 16'sd0);
      send_point(16'sd0, -16'sd1);
      drain_results();
   endtask

   // largest grid and radius, centers at the corners and coordinate extremes
   task automatic test_extremes();
      set_grid(13'd31, 13'd4096, 13'd4096);
      send_point(16'sd0, 16'sd0);
      send_point(16'sd4095, 16'sd4095);
      send_point(16'sd2048, 16'sd2048);
      send_point(-16'sd32768, -16'sd32768);
      send_point(16'sd32767, 16'sd32767);
      send_point(-16'sd31, 16'sd10);
      send_point(-16'sd32, 16'sd10);
      send_point(16'sd100, -16'sd31);
      send_point(16'sd100, 16'sd4126);
      drain_results();
      // full radius on a one-cell grid
      set_grid(13'd31, 13'd1, 13'd1);
      send_point(16'sd0, 16'sd0);
      send_point(16'sd20, -16'sd20);
      drain_results();
   endtask

   // upper register bits are dropped, oversize sides clamp, unused index is ignored
   task automatic test_register_masking();
      set_grid(13'h1FE3, 13'h1FFF, 13'd5000);
      write_reg(REG_UNUSED_INDEX, 13'h1FFF);
      csr_ch.valid <= 1'b0;
      send_point(16'sd4095, 16'sd0);
      send_point(16'sd10, 16'sd4094);
      drain_results();
   endtask

   // a zero width or height leaves nothing inside the grid
   task automatic test_zero_sides();
      set_grid(13'd4, 13'd0, 13'd16);
      send_point(16'sd0, 16'sd5);
      send_point(16'sd3, 16'sd0);
      drain_results();
      set_grid(13'd4, 13'd16, 13'd0);
      send_point(16'sd5, 16'sd0);
      drain_results();
   endtask

   // random settings, centers mostly around the grid
   task automatic test_random_shapes();
      logic [CSR_DATA_W-1:0] radius_data, width_data, height_data;
      for (int phase = 0; phase < 7; phase++) begin
         radius_data = CSR_DATA_W'($urandom_range(31));
         width_data  = CSR_DATA_W'($urandom_range(80, 1));
         height_data = CSR_DATA_W'($urandom_range(80, 1));
         if (phase == 0) radius_data = 13'd31;
         if (phase == 1) radius_data = 13'd0;
         if (phase == 2) begin
            width_data  = 13'd4096;
            height_data = 13'd4096;
         end
         if (phase == 3) width_data = 13'd1;
         set_grid(radius_data, width_data, height_data);
         repeat (50) send_near_point();
         drain_results();
      end
   endtask

   // centers anywhere in the coordinate range, then with columns limited to 0..4200
   task automatic test_random_noise();
      set_grid(13'd20, 13'd4096, 13'd4096);
      repeat (30) send_point(COORD_W'($urandom), COORD_W'($urandom));
      repeat (30) send_point(COORD_W'($urandom_range(4200)), COORD_W'($urandom));
      drain_results();
   endtask

   // hold the output while large disks keep coming, so the input backs up
   task automatic test_output_backpressure();
      set_grid(13'd31, 13'd100, 13'd100);
      long_hold_pending = 1'b1;
      burst_left = 30;
      repeat (30) send_near_point();
      drain_results();
   endtask

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.center_col <= '0;
      req_ch.center_row <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= REG_DISK_RADIUS;
      csr_ch.data       <= '0;
      cfg_radius    = 0;
      cfg_width     = 1;
      cfg_height    = 1;
      span_count    = '0;
      mismatches    = 0;
      points_sent   = 0;
      spans_seen    = 0;
      empties_seen  = 0;
      settings_used = 0;
      burst_left    = 0;
      idle_cycles   = 0;
      long_hold_pending = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_extremes();
      test_register_masking();
      test_zero_sides();
      test_random_shapes();
      test_random_noise();
      test_output_backpressure();

      if (span_queue.size() != 0) begin
         note_mismatch($sformatf("%0d expected spans never arrived", span_queue.size()));
      end
      $display("Ran %0d points through %0d register settings, %0d spans back (%0d empty).",
               points_sent, settings_used, spans_seen, empties_seen);
      $display("Included grid extremes, masked writes and a %0d-cycle output hold-off.",
               HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches in total", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
